>>> src/yuvblend_pkg.sv
// shared constants for the yuv420 overlay alpha blend
`timescale 1ns / 1ps

package yuvblend_pkg;

   // configuration register indexes
   typedef enum logic [3:0] {
      CSR_OVERLAY_X        = 4'd0,
      CSR_OVERLAY_Y        = 4'd1,
      CSR_SOURCE_WIDTH     = 4'd2,
      CSR_SOURCE_HEIGHT    = 4'd3,
      CSR_FRAME_WIDTH      = 4'd4,
      CSR_FRAME_HEIGHT     = 4'd5,
      CSR_GLOBAL_ALPHA     = 4'd6,
      CSR_USE_SOURCE_ALPHA = 4'd7
   } csr_index_type;

   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 13;
   localparam int unsigned OFFSET_BITS    = 13;
   localparam int unsigned SIZE_BITS      = 12;
   localparam int unsigned SAMPLE_BITS    = 8;

   localparam logic [1:0]  PLANE_LUMA   = 2'd0;
   localparam logic [7:0]  ALPHA_MAX    = 8'd255;
   localparam logic [16:0] ROUND_BIAS   = 17'd128;

endpackage

>>> src/yuv420_overlay_alpha_blend.sv
// yuv420 overlay alpha blend: clip, alpha select and blend of one sample per cycle
//
//  channel   ports                                       direction  handshake
//  request   start, busy, req_*                          in         start & !busy
//  response  rsp_strobe, rsp_result_sample, rsp_covered  out        strobe, one cycle
//  csr       csr_valid, csr_ready, csr_index, csr_data   in         valid & ready
//
// four register stages: offset/size and alpha sums, clip compares and alpha
// select, the two products, then the rounded divide by 255 into the output.
// an item may start every cycle; its result strobes from the stage 4 output register.
// busy and csr_ready are always deasserted/asserted since nothing can stall.
// reset is synchronous, active high; it clears the valid bits and csr registers.
`timescale 1ns / 1ps

module yuv420_overlay_alpha_blend
   import yuvblend_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_plane,
   input  logic [COORD_BITS-1:0]     req_dest_col,
   input  logic [COORD_BITS-1:0]     req_dest_row,
   input  logic [SAMPLE_BITS-1:0]    req_frame_sample,
   input  logic [SAMPLE_BITS-1:0]    req_overlay_sample,
   input  logic [SAMPLE_BITS-1:0]    req_alpha_top_left,
   input  logic [SAMPLE_BITS-1:0]    req_alpha_top_right,
   input  logic [SAMPLE_BITS-1:0]    req_alpha_bottom_left,
   input  logic [SAMPLE_BITS-1:0]    req_alpha_bottom_right,

   output logic                      rsp_strobe,
   output logic [SAMPLE_BITS-1:0]    rsp_result_sample,
   output logic                      rsp_covered,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // size width covers both the register and the coordinate width
   localparam int SW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int AW = SW + 3;
   localparam logic [SW-1:0] COORD_MASK = SW'({COORD_BITS{1'b1}});

   // ---------------- configuration registers ----------------
   logic signed [OFFSET_BITS-1:0] overlay_x_ff, overlay_y_ff;
   logic [SIZE_BITS-1:0]          source_width_ff, source_height_ff;
   logic [SIZE_BITS-1:0]          frame_width_ff, frame_height_ff;
   logic [SAMPLE_BITS-1:0]        global_alpha_ff;
   logic                          use_source_alpha_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_x_ff        <= '0;
         overlay_y_ff        <= '0;
         source_width_ff     <= '0;
         source_height_ff    <= '0;
         frame_width_ff      <= '0;
         frame_height_ff     <= '0;
         global_alpha_ff     <= '0;
         use_source_alpha_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OVERLAY_X:        overlay_x_ff        <= $signed(csr_data);
            CSR_OVERLAY_Y:        overlay_y_ff        <= $signed(csr_data);
            CSR_SOURCE_WIDTH:     source_width_ff     <= csr_data[SIZE_BITS-1:0];
            CSR_SOURCE_HEIGHT:    source_height_ff    <= csr_data[SIZE_BITS-1:0];
            CSR_FRAME_WIDTH:      frame_width_ff      <= csr_data[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT:     frame_height_ff     <= csr_data[SIZE_BITS-1:0];
            CSR_GLOBAL_ALPHA:     global_alpha_ff     <= csr_data[SAMPLE_BITS-1:0];
            CSR_USE_SOURCE_ALPHA: use_source_alpha_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: plane scaling, offsets, alpha sums ----------------
   logic                   s1_valid_ff;
   logic                   s1_chroma_ff, s1_chroma_in;
   logic signed [AW-1:0]   s1_col_ff, s1_col_in;
   logic signed [AW-1:0]   s1_row_ff, s1_row_in;
   logic [SW-1:0]          s1_c_ff, s1_r_ff;
   logic [SW-1:0]          s1_srcw_ff, s1_srcw_in, s1_srch_ff, s1_srch_in;
   logic [SW-1:0]          s1_dstw_ff, s1_dstw_in, s1_dsth_ff, s1_dsth_in;
   logic [SAMPLE_BITS-1:0] s1_fs_ff, s1_os_ff, s1_tl_ff;
   logic [SAMPLE_BITS-1:0] s1_hpair_ff, s1_hpair_in, s1_vpair_ff, s1_vpair_in;
   logic [SAMPLE_BITS-1:0] s1_quad_ff, s1_quad_in;

   logic signed [OFFSET_BITS-1:0] ox, oy;
   logic [SW-1:0]                 c_ext, r_ext;
   logic [SAMPLE_BITS:0]          sum_h, sum_v;
   logic [SAMPLE_BITS+1:0]        sum_q;

   always_comb begin
      s1_chroma_in = (req_plane != PLANE_LUMA);
      // arithmetic shift is the floor halving of the offset
      ox = s1_chroma_in ? (overlay_x_ff >>> 1) : overlay_x_ff;
      oy = s1_chroma_in ? (overlay_y_ff >>> 1) : overlay_y_ff;
      s1_srcw_in = (SW'(source_width_ff)  & COORD_MASK) >> s1_chroma_in;
      s1_srch_in = (SW'(source_height_ff) & COORD_MASK) >> s1_chroma_in;
      s1_dstw_in = (SW'(frame_width_ff)   & COORD_MASK) >> s1_chroma_in;
      s1_dsth_in = (SW'(frame_height_ff)  & COORD_MASK) >> s1_chroma_in;
      c_ext = SW'(req_dest_col);
      r_ext = SW'(req_dest_row);
      s1_col_in = $signed({3'b000, c_ext}) - AW'(ox);
      s1_row_in = $signed({3'b000, r_ext}) - AW'(oy);
      sum_h = {1'b0, req_alpha_top_left} + {1'b0, req_alpha_top_right};
      sum_v = {1'b0, req_alpha_top_left} + {1'b0, req_alpha_bottom_left};
      sum_q = {1'b0, sum_h} + {2'b00, req_alpha_bottom_left}
            + {2'b00, req_alpha_bottom_right};
      s1_hpair_in = sum_h[SAMPLE_BITS:1];
      s1_vpair_in = sum_v[SAMPLE_BITS:1];
      s1_quad_in  = sum_q[SAMPLE_BITS+1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      s1_chroma_ff <= s1_chroma_in;
      s1_col_ff    <= s1_col_in;
      s1_row_ff    <= s1_row_in;
      s1_c_ff      <= c_ext;
      s1_r_ff      <= r_ext;
      s1_srcw_ff   <= s1_srcw_in;
      s1_srch_ff   <= s1_srch_in;
      s1_dstw_ff   <= s1_dstw_in;
      s1_dsth_ff   <= s1_dsth_in;
      s1_fs_ff     <= req_frame_sample;
      s1_os_ff     <= req_overlay_sample;
      s1_tl_ff     <= req_alpha_top_left;
      s1_hpair_ff  <= s1_hpair_in;
      s1_vpair_ff  <= s1_vpair_in;
      s1_quad_ff   <= s1_quad_in;
   end

   // ---------------- stage 2: clipping and alpha selection ----------------
   logic                   s2_valid_ff;
   logic                   s2_cov_ff, s2_cov_in;
   logic [SAMPLE_BITS-1:0] s2_alpha_ff, s2_alpha_in;
   logic [SAMPLE_BITS-1:0] s2_fs_ff, s2_os_ff;

   logic signed [AW-1:0]   srcw_s, srch_s;
   logic [SW:0]            c_next, r_next;
   logic                   col_in, row_in;
   logic [SAMPLE_BITS-1:0] hv, vv;
   logic [SAMPLE_BITS:0]   hv_vv;

   always_comb begin
      srcw_s = $signed({3'b000, s1_srcw_ff});
      srch_s = $signed({3'b000, s1_srch_ff});
      c_next = {1'b0, s1_c_ff} + 1'b1;
      r_next = {1'b0, s1_r_ff} + 1'b1;
      s2_cov_in = (s1_c_ff < s1_dstw_ff) && (s1_r_ff < s1_dsth_ff)
                && (s1_col_ff >= 0) && (s1_col_ff < srcw_s)
                && (s1_row_ff >= 0) && (s1_row_ff < srch_s);
      // a 2x2 neighbor counts only while it stays inside the clipped area
      col_in = (c_next < {1'b0, s1_dstw_ff}) && ((s1_col_ff + 2'sd1) < srcw_s);
      row_in = (r_next < {1'b0, s1_dsth_ff}) && ((s1_row_ff + 2'sd1) < srch_s);
      hv    = col_in ? s1_hpair_ff : s1_tl_ff;
      vv    = row_in ? s1_vpair_ff : s1_tl_ff;
      hv_vv = {1'b0, hv} + {1'b0, vv};
      if (!use_source_alpha_ff)  s2_alpha_in = global_alpha_ff;
      else if (!s1_chroma_ff)    s2_alpha_in = s1_tl_ff;
      else if (col_in && row_in) s2_alpha_in = s1_quad_ff;
      else                       s2_alpha_in = hv_vv[SAMPLE_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_cov_ff   <= s2_cov_in;
      s2_alpha_ff <= s2_alpha_in;
      s2_fs_ff    <= s1_fs_ff;
      s2_os_ff    <= s1_os_ff;
   end

   // ---------------- stage 3: weighted products ----------------
   logic                       s3_valid_ff;
   logic                       s3_cov_ff;
   logic [SAMPLE_BITS-1:0]     s3_fs_ff;
   logic [2*SAMPLE_BITS-1:0]   s3_fprod_ff, s3_fprod_in, s3_oprod_ff, s3_oprod_in;

   always_comb begin
      s3_fprod_in = s2_fs_ff * s2_alpha_ff;
      s3_oprod_in = s2_os_ff * (ALPHA_MAX - s2_alpha_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      s3_cov_ff   <= s2_cov_ff;
      s3_fs_ff    <= s2_fs_ff;
      s3_fprod_ff <= s3_fprod_in;
      s3_oprod_ff <= s3_oprod_in;
   end

   // ---------------- stage 4: rounded divide by 255, output ----------------
   logic                   out_valid_ff;
   logic                   out_cov_ff;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;

   logic [16:0] v_sum;
   logic [25:0] v_scaled;

   always_comb begin
      v_sum    = {1'b0, s3_fprod_ff} + {1'b0, s3_oprod_ff} + ROUND_BIAS;
      // times 257 as shift and add
      v_scaled = {1'b0, v_sum, 8'h00} + {9'h000, v_sum};
      out_sample_in = s3_cov_ff ? v_scaled[23:16] : s3_fs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      out_cov_ff    <= s3_cov_ff;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_result_sample = out_sample_ff;
   assign rsp_covered       = out_cov_ff;

endmodule
